// ----- rtl/tmd_pkg.sv -----
`timescale 1ns / 1ps

package tmd_pkg;

  // Defaults for the top-level parameters
  localparam int NUM_CHANNELS_DEF = 2;
  localparam int SAMPLE_BITS_DEF  = 24;

  // Fixed field widths
  localparam int COEFF_W   = 16;
  localparam int RED_W     = 16;
  localparam int CFG_IDX_W = 2;

  // Register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 2'd1;

  // Coefficient reset values, Q0.16
  localparam logic [COEFF_W-1:0] ATTACK_RESET  = 16'd1351;
  localparam logic [COEFF_W-1:0] RELEASE_RESET = 16'd27;

  // Reduction smoother: 0.01 in Q0.16, and full scale
  localparam logic [9:0]       SMOOTH_COEFF = 10'd655;
  localparam logic [RED_W-1:0] RED_MAX      = 16'hFFFF;

endpackage

// ----- rtl/transient_masking_detector.sv -----
`timescale 1ns / 1ps

// Channel  Direction  Handshake            Payload
// in_      input      in_valid / in_stall  in_channel_index, in_sample_value
// out_     output     out_valid/out_stall  out_channel, out_reduction_out, out_envelope_out
// cfg_     input      cfg_we               cfg_index, cfg_data
//
// Two-stage pipeline: one transaction per cycle while out_stall is low; an
// accepted transaction passes the middle register, then the result register,
// where out_valid rises. Stage one (envelope multiply) and stage two
// (strength and smoother multiply) each keep their own per-channel state.
// Reset is synchronous: stores clear to zero, coefficients to defaults.
// A stalled output holds; the middle register still fills, so in_stall rises
// only when both pipeline registers hold transactions and out_stall is high.
module transient_masking_detector #(
  parameter int NUM_CHANNELS = tmd_pkg::NUM_CHANNELS_DEF,
  parameter int SAMPLE_BITS  = tmd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [tmd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tmd_pkg::COEFF_W-1:0]     cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_channel_index,
  input  logic signed [SAMPLE_BITS-1:0]   in_sample_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_channel,
  output logic [tmd_pkg::RED_W-1:0]       out_reduction_out,
  output logic [SAMPLE_BITS-1:0]          out_envelope_out
);
  import tmd_pkg::*;

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [IDX_W-1:0] LAST_CH = IDX_W'(NUM_CHANNELS - 1);

  logic [COEFF_W-1:0] attack_r, release_r;

  logic                   mid_valid_r;
  logic                   mid_ch_r;
  logic [IDX_W-1:0]       mid_idx_r;
  logic [SAMPLE_BITS-1:0] mid_env_r;

  logic                   out_valid_r;
  logic                   out_ch_r;
  logic [RED_W-1:0]       out_red_r;
  logic [SAMPLE_BITS-1:0] out_env_r;

  logic                   out_en, mid_en, in_fire, mid_fire;
  logic [IDX_W-1:0]       in_idx;
  logic [SAMPLE_BITS-1:0] env_new;
  logic [RED_W-1:0]       red_new;

  // Config registers; other indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_r  <= ATTACK_RESET;
      release_r <= RELEASE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ATTACK:  attack_r  <= cfg_data;
        REG_RELEASE: release_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Per-stage enables: a register loads when empty or when it drains
  assign out_en   = !out_valid_r || !out_stall;
  assign mid_en   = !mid_valid_r || out_en;
  assign in_stall = !mid_en;
  assign in_fire  = in_valid && mid_en;
  assign mid_fire = mid_valid_r && out_en;

  // Channels past the last one share the last channel's state
  assign in_idx = (32'(in_channel_index) < NUM_CHANNELS) ? IDX_W'(in_channel_index) : LAST_CH;

  tmd_env_stage #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .SAMPLE_BITS  (SAMPLE_BITS),
    .IDX_W        (IDX_W)
  ) u_env (
    .clk           (clk),
    .rst_n         (rst_n),
    .upd           (in_fire),
    .idx           (in_idx),
    .sample        (in_sample_value),
    .attack_coeff  (attack_r),
    .release_coeff (release_r),
    .env_new       (env_new)
  );

  // Middle register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_valid_r <= 1'b0;
    end else if (mid_en) begin
      mid_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      mid_ch_r  <= in_channel_index;
      mid_idx_r <= in_idx;
      mid_env_r <= env_new;
    end
  end

  tmd_red_stage #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .SAMPLE_BITS  (SAMPLE_BITS),
    .IDX_W        (IDX_W)
  ) u_red (
    .clk     (clk),
    .rst_n   (rst_n),
    .upd     (mid_fire),
    .idx     (mid_idx_r),
    .env     (mid_env_r),
    .red_new (red_new)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_en) begin
      out_valid_r <= mid_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_fire) begin
      out_ch_r  <= mid_ch_r;
      out_red_r <= red_new;
      out_env_r <= mid_env_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_channel       = out_ch_r;
  assign out_reduction_out = out_red_r;
  assign out_envelope_out  = out_env_r;

  // Input only stalls while the middle register is occupied
  a_stall_needs_mid: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> mid_valid_r)
    else $error("in_stall with empty middle register");

  // An accepted transaction lands in the middle register
  a_accept_to_mid: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> mid_valid_r)
    else $error("accepted transaction lost before middle register");

  // A middle transaction moves to the output when the output is free
  a_mid_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (mid_valid_r && !(out_valid_r && out_stall)) |=> out_valid_r)
    else $error("middle transaction lost before result register");

endmodule

// ----- rtl/tmd_env_stage.sv -----
`timescale 1ns / 1ps

// Envelope stage: per-channel previous sample and attack/release envelope.
// The new envelope is combinational from the input ports; the stores
// update when a transaction is accepted.
module tmd_env_stage #(
  parameter int NUM_CHANNELS = tmd_pkg::NUM_CHANNELS_DEF,
  parameter int SAMPLE_BITS  = tmd_pkg::SAMPLE_BITS_DEF,
  parameter int IDX_W        = 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          upd,
  input  logic [IDX_W-1:0]              idx,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic [tmd_pkg::COEFF_W-1:0]   attack_coeff,
  input  logic [tmd_pkg::COEFF_W-1:0]   release_coeff,
  output logic [SAMPLE_BITS-1:0]        env_new
);
  import tmd_pkg::*;

  localparam int W = SAMPLE_BITS;

  logic signed [W-1:0] prev_r [NUM_CHANNELS];
  logic        [W-1:0] env_r  [NUM_CHANNELS];

  logic signed [W-1:0]         prev;
  logic        [W-1:0]         env;
  logic signed [W:0]           delta;
  logic        [W-1:0]         diff;
  logic        [COEFF_W-1:0]   coeff;
  logic signed [W:0]           gap;
  logic signed [W+COEFF_W:0]   prod;
  logic signed [W:0]           step;
  logic signed [W+1:0]         sum;

  assign prev = prev_r[idx];
  assign env  = env_r[idx];

  // Absolute difference from the channel's previous sample
  assign delta = {sample[W-1], sample} - {prev[W-1], prev};
  assign diff  = delta[W] ? W'(-delta) : delta[W-1:0];

  // Attack when the difference rises above the envelope
  assign coeff = (diff > env) ? attack_coeff : release_coeff;

  // env += floor(coeff * (diff - env) / 2^16)
  assign gap  = $signed({1'b0, diff}) - $signed({1'b0, env});
  assign prod = $signed({1'b0, coeff}) * gap;
  assign step = (W+1)'(prod >>> COEFF_W);
  assign sum  = $signed({2'b00, env}) + {step[W], step};

  always_comb begin
    if (sum[W+1]) begin
      env_new = '0;
    end else if (sum[W]) begin
      env_new = '1;
    end else begin
      env_new = sum[W-1:0];
    end
  end

  // Per-channel state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        prev_r[i] <= '0;
        env_r[i]  <= '0;
      end
    end else if (upd) begin
      prev_r[idx] <= sample;
      env_r[idx]  <= env_new;
    end
  end

endmodule

// ----- rtl/tmd_red_stage.sv -----
`timescale 1ns / 1ps

// Reduction stage: strength = 20 * envelope saturated at full scale,
// then a slow one-pole smoother per channel.
module tmd_red_stage #(
  parameter int NUM_CHANNELS = tmd_pkg::NUM_CHANNELS_DEF,
  parameter int SAMPLE_BITS  = tmd_pkg::SAMPLE_BITS_DEF,
  parameter int IDX_W        = 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        upd,
  input  logic [IDX_W-1:0]            idx,
  input  logic [SAMPLE_BITS-1:0]      env,
  output logic [tmd_pkg::RED_W-1:0]   red_new
);
  import tmd_pkg::*;

  localparam int W = SAMPLE_BITS;

  logic [RED_W-1:0] red_r [NUM_CHANNELS];

  logic        [RED_W-1:0]     red;
  logic        [W+4:0]         scaled;
  logic        [W+RED_W-2:0]   frac;
  logic        [RED_W-1:0]     strength;
  logic signed [RED_W:0]       gap;
  logic signed [RED_W+11:0]    prod;
  logic signed [11:0]          step;
  logic signed [RED_W+1:0]     sum;

  assign red = red_r[idx];

  // envelope * 20 as a shift-add
  assign scaled = ((W+5)'(env) << 4) + ((W+5)'(env) << 2);

  // Q1.(W-1) to Q0.16, full scale at and above 1.0
  assign frac = {scaled[W-2:0], {RED_W{1'b0}}} >> (W - 1);
  assign strength = (scaled >= (W+5)'(1) << (W - 1)) ? RED_MAX : frac[RED_W-1:0];

  // red += floor(655 * (strength - red) / 2^16)
  assign gap  = $signed({1'b0, strength}) - $signed({1'b0, red});
  assign prod = $signed({1'b0, SMOOTH_COEFF}) * gap;
  assign step = 12'(prod >>> RED_W);
  assign sum  = $signed({2'b00, red}) + {{(RED_W-10){step[11]}}, step};

  always_comb begin
    if (sum[RED_W+1]) begin
      red_new = '0;
    end else if (sum[RED_W]) begin
      red_new = RED_MAX;
    end else begin
      red_new = sum[RED_W-1:0];
    end
  end

  // Per-channel state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        red_r[i] <= '0;
      end
    end else if (upd) begin
      red_r[idx] <= red_new;
    end
  end

endmodule

// ----- tb/sv/transient_masking_detector_tb.sv -----
`timescale 1ns / 1ps

module transient_masking_detector_tb;
  import tmd_pkg::*;

  localparam int NCH = NUM_CHANNELS_DEF;
  localparam int SB  = SAMPLE_BITS_DEF;
  localparam int GAIN = 20;
  localparam int LATENCY = 2;
  localparam int HOLD_CYCLES = 48;
  localparam int PHASE_ITEMS = 67;

  // Indexes past the last register; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE3 = 2'd3;

  localparam logic signed [SB-1:0] SMP_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] SMP_MIN = {1'b1, {(SB-1){1'b0}}};

  // Per-channel envelope / reduction predictor plus queue of results still due
  class tmd_scoreboard;
    typedef struct {
      logic             channel;
      logic [RED_W-1:0] reduction;
      logic [SB-1:0]    envelope;
    } result_t;

    result_t          due_results[$];
    logic [COEFF_W-1:0] atk_coeff;
    logic [COEFF_W-1:0] rel_coeff;
    longint           prev_smp[NCH];
    longint           env_st[NCH];
    longint           red_st[NCH];
    int               errors;
    int               n_checked;
    int               n_attack;
    int               n_saturated;

    function new();
      atk_coeff = ATTACK_RESET;
      rel_coeff = RELEASE_RESET;
      foreach (prev_smp[c]) begin
        prev_smp[c] = 0;
        env_st[c]   = 0;
        red_st[c]   = 0;
      end
      errors      = 0;
      n_checked   = 0;
      n_attack    = 0;
      n_saturated = 0;
    endfunction

    function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [COEFF_W-1:0] data);
      if (idx == REG_ATTACK) atk_coeff = data;
      else if (idx == REG_RELEASE) rel_coeff = data;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    // Accepted sample: advance the channel state and queue its result
    function void note_sample(logic ch, logic signed [SB-1:0] smp);
      int      c;
      longint  diff, env, coeff, scaled, strength, red, env_max;
      result_t r;
      c = (int'(ch) >= NCH) ? NCH - 1 : int'(ch);
      env_max = (longint'(1) << SB) - 1;

      diff = longint'(smp) - prev_smp[c];
      if (diff < 0) diff = -diff;
      prev_smp[c] = smp;

      // attack/release one-pole on the absolute difference
      env = env_st[c];
      if (diff > env) begin
        coeff = atk_coeff;
        n_attack++;
      end else begin
        coeff = rel_coeff;
      end
      env = env + ((coeff * (diff - env)) >>> 16);
      if (env < 0) env = 0;
      if (env > env_max) env = env_max;
      env_st[c] = env;

      // gain of 20, full scale maps to the top code
      scaled = env * GAIN;
      if (scaled >= (longint'(1) << (SB - 1))) begin
        strength = RED_MAX;
        n_saturated++;
      end else begin
        strength = (scaled << 16) >> (SB - 1);
      end
      if (strength > RED_MAX) strength = RED_MAX;

      // slow smoother toward the strength
      red = red_st[c];
      red = red + ((longint'(SMOOTH_COEFF) * (strength - red)) >>> 16);
      if (red < 0) red = 0;
      if (red > RED_MAX) red = RED_MAX;
      red_st[c] = red;

      r.channel   = ch;
      r.reduction = red[RED_W-1:0];
      r.envelope  = env[SB-1:0];
      due_results.push_back(r);
    endfunction

    function void check_result(logic ch, logic [RED_W-1:0] red, logic [SB-1:0] env);
      result_t want;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing due: ch %0d reduction %0d envelope %0d",
                 $time, ch, red, env);
        return;
      end
      want = due_results.pop_front();
      n_checked++;
      if (ch !== want.channel || red !== want.reduction || env !== want.envelope) begin
        errors++;
        $display("%0t: mismatch expected ch %0d red %0d env %0d, actual ch %0d red %0d env %0d",
                 $time, want.channel, want.reduction, want.envelope, ch, red, env);
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COEFF_W-1:0]   cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_channel_index;
  logic signed [SB-1:0] in_sample_value;
  logic                 out_valid;
  logic                 out_stall;
  logic                 out_channel;
  logic [RED_W-1:0]     out_reduction_out;
  logic [SB-1:0]        out_envelope_out;

  tmd_scoreboard sb;
  bit            tx_idle_en;
  bit            rx_idle_en;
  bit            hold_req;
  int            in_held_cycles;

  transient_masking_detector i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_channel_index (in_channel_index),
    .in_sample_value  (in_sample_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_channel      (out_channel),
    .out_reduction_out(out_reduction_out),
    .out_envelope_out (out_envelope_out)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Transaction monitor on both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_sample(in_channel_index, in_sample_value);
      if (in_valid && in_stall) in_held_cycles++;
      if (out_valid && !out_stall) sb.check_result(out_channel, out_reduction_out,
                                                   out_envelope_out);
    end
  end

  // Result side: random stall bursts, plus one long hold-off on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #2000000;
    $display("FAIL transient_masking_detector");
    $finish;
  end

  // Offer one sample and hold it until the block takes it
  task automatic send_sample(input logic ch, input logic signed [SB-1:0] smp);
    in_valid         <= 1'b1;
    in_channel_index <= ch;
    in_sample_value  <= smp;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEFF_W-1:0] data);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.apply_reg(idx, data);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic                 ch;
    logic signed [SB-1:0] smp;
    logic signed [SB-1:0] last_smp [NCH];
    logic [COEFF_W-1:0]   atk, rel;

    sb = new();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    hold_req   = 1'b0;
    in_held_cycles = 0;
    foreach (last_smp[c]) last_smp[c] = '0;

    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= REG_ATTACK;
    cfg_data         <= '0;
    in_valid         <= 1'b0;
    in_channel_index <= 1'b0;
    in_sample_value  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: default coefficients, zero step, full-scale swings, tiny steps
    send_sample(1'b0, '0);
    send_sample(1'b0, SMP_MAX);
    send_sample(1'b0, SMP_MIN);
    send_sample(1'b0, SMP_MIN);
    send_sample(1'b1, SMP_MIN);
    send_sample(1'b1, SMP_MAX);
    send_sample(1'b1, '1);
    send_sample(1'b1, SB'(1));
    send_sample(1'b1, '0);
    send_sample(1'b0, SB'(1));
    send_sample(1'b0, SB'(1) <<< (SB - 2));

    // Top coefficients: envelope jumps nearly to the difference, strength saturates
    write_reg(REG_ATTACK, '1);
    write_reg(REG_RELEASE, '1);
    write_reg(REG_SPARE2, COEFF_W'($urandom));
    write_reg(REG_SPARE3, COEFF_W'($urandom));
    send_sample(1'b0, SMP_MAX);
    send_sample(1'b0, SMP_MIN);
    send_sample(1'b1, SMP_MAX);
    send_sample(1'b1, SMP_MAX);
    send_sample(1'b0, '0);

    // Zero coefficients: envelope frozen
    write_reg(REG_ATTACK, '0);
    write_reg(REG_RELEASE, '0);
    send_sample(1'b0, SMP_MAX);
    send_sample(1'b1, '0);
    send_sample(1'b1, SMP_MIN);

    // Random phases over several coefficient settings; last one runs flat out
    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       begin atk = ATTACK_RESET; rel = RELEASE_RESET; end
        1:       begin atk = '1;           rel = '0;            end
        2:       begin atk = '0;           rel = '1;            end
        5:       begin atk = ATTACK_RESET; rel = RELEASE_RESET; end
        default: begin atk = COEFF_W'($urandom); rel = COEFF_W'($urandom_range(0, 4095)); end
      endcase
      write_reg(REG_ATTACK, atk);
      write_reg(REG_RELEASE, rel);
      tx_idle_en = (p != 5);
      rx_idle_en = (p != 5);

      // back-pressure: receiver holds off while samples keep coming
      if (p == 3) begin
        hold_req = 1'b1;
        for (int k = 0; k < 30; k++) begin
          ch  = 1'($urandom_range(0, 1));
          smp = SB'($urandom);
          last_smp[ch] = smp;
          send_sample(ch, smp);
        end
      end

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == 50) begin
          tx_idle_en = 1'b0;
          rx_idle_en = 1'b0;
        end
        ch = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: smp = SB'($urandom);
          5, 6:          smp = SB'($urandom_range(0, 1023)) - SB'(512);
          7: begin
            case ($urandom_range(0, 3))
              0:       smp = SMP_MAX;
              1:       smp = SMP_MIN;
              2:       smp = '0;
              default: smp = '1;
            endcase
          end
          default:       smp = last_smp[ch] + SB'($urandom_range(0, 255)) - SB'(128);
        endcase
        last_smp[ch] = smp;
        send_sample(ch, smp);
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 12)) @(posedge clk);
        end
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);

    $display("Checked %0d results: %0d attack steps, %0d with saturated strength.",
             sb.n_checked, sb.n_attack, sb.n_saturated);
    $display("Default, zero, full-scale and random coefficients; input held %0d cycles.",
             in_held_cycles);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS transient_masking_detector");
    end else begin
      $display("FAIL transient_masking_detector");
    end
    $finish;
  end

endmodule
